/* hdl/cut_minterm_histogram_top_macros.svh */
// assertion macros for the minterm histogram top level
`ifndef CUT_MINTERM_HISTOGRAM_TOP_MACROS_SVH
`define CUT_MINTERM_HISTOGRAM_TOP_MACROS_SVH

// condition in the same cycle
`define CMH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cmh: same-cycle check failed");

// condition in the next cycle
`define CMH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cmh: next-cycle check failed");

`endif

/* hdl/cmh_pkg.sv */
`timescale 1ns / 1ps

package cmh_pkg;

    localparam int NUM_MINTERMS = 16;
    localparam int NUM_LEAVES   = 4;
    localparam int MINT_W       = 4;
    localparam int CNT_W        = 16;
    localparam int LEAF_W       = 3;
    localparam int IN_W         = 32;
    localparam int GROUP_BITS   = 8;

    localparam logic [CNT_W-1:0]  COUNT_MAX        = 16'hFFFF;
    localparam logic [LEAF_W-1:0] LEAF_COUNT_RESET = 3'd4;
    localparam logic [MINT_W-1:0] LAST_MINTERM     = 4'hF;

    typedef logic [MINT_W-1:0] mint_t;
    typedef logic [CNT_W-1:0]  count_t;

    // one histogram result as held in the output register
    typedef struct packed {
        logic                    valid;
        mint_t                   minterm;
        count_t                  occurrences;
        logic [NUM_MINTERMS-1:0] seen_mask;
        logic                    last_of_run;
    } result_t;

endpackage

/* hdl/cmh_front.sv */
`timescale 1ns / 1ps

module cmh_front #(
    parameter int LIVE_BITS = 32
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_stall,
    input  logic [cmh_pkg::IN_W-1:0]                   word_leaf0,
    input  logic [cmh_pkg::IN_W-1:0]                   word_leaf1,
    input  logic [cmh_pkg::IN_W-1:0]                   word_leaf2,
    input  logic [cmh_pkg::IN_W-1:0]                   word_leaf3,
    input  logic                                       final_word,
    input  logic [cmh_pkg::LEAF_W-1:0]                 leaf_count,
    output logic                                       q_valid,
    input  logic                                       q_ready,
    output cmh_pkg::mint_t [LIVE_BITS-1:0]             q_mints,
    output logic                                       q_final
);

    logic                                  accept;
    logic [cmh_pkg::NUM_LEAVES-1:0]        leaf_en;
    logic [cmh_pkg::NUM_LEAVES-1:0][cmh_pkg::IN_W-1:0] words;
    cmh_pkg::mint_t [LIVE_BITS-1:0]        mints_next;

    logic                                  f_valid_reg;
    logic                                  f_final_reg;
    cmh_pkg::mint_t [LIVE_BITS-1:0]        f_mints_reg;

    // hold the request while the queue is full
    assign in_stall = f_valid_reg && !q_ready;
    assign accept   = in_valid && !in_stall;

    assign words = {word_leaf3, word_leaf2, word_leaf1, word_leaf0};

    // leaf enables and per-position minterm codes
    always_comb
    begin
        for (int b = 0; b < cmh_pkg::NUM_LEAVES; b++)
        begin
            leaf_en[b] = (leaf_count > cmh_pkg::LEAF_W'(b));
        end
        for (int k = 0; k < LIVE_BITS; k++)
        begin
            for (int b = 0; b < cmh_pkg::NUM_LEAVES; b++)
            begin
                mints_next[k][b] = leaf_en[b] & words[b][k];
            end
        end
    end

    // front register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            f_valid_reg <= 1'b1;
        end
        else if (q_ready)
        begin
            f_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_mints_reg <= mints_next;
            f_final_reg <= final_word;
        end
    end

    assign q_valid = f_valid_reg;
    assign q_mints = f_mints_reg;
    assign q_final = f_final_reg;

endmodule

/* hdl/cmh_fifo.sv */
`timescale 1ns / 1ps

module cmh_fifo #(
    parameter int WIDTH = 129
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic [1:0]       count_reg;
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* hdl/cmh_back.sv */
`timescale 1ns / 1ps

module cmh_back #(
    parameter int WORD_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  cmh_pkg::mint_t [((WORD_BITS < cmh_pkg::IN_W) ? WORD_BITS : cmh_pkg::IN_W)-1:0]
                                                q_mints,
    input  logic                                q_final,
    input  logic                                out_stall,
    output cmh_pkg::result_t                    res
);

    localparam int LIVE_BITS = (WORD_BITS < cmh_pkg::IN_W) ? WORD_BITS : cmh_pkg::IN_W;
    localparam int PAD_BITS  = WORD_BITS - LIVE_BITS;
    localparam int GROUPS    = (LIVE_BITS + cmh_pkg::GROUP_BITS - 1) / cmh_pkg::GROUP_BITS;
    localparam int GCNT_W    = $clog2(cmh_pkg::GROUP_BITS + 1);
    localparam int TOT_W     = $clog2(WORD_BITS + 1);
    localparam int SUM_W     = cmh_pkg::CNT_W + 1;
    localparam int NM        = cmh_pkg::NUM_MINTERMS;

    logic [GCNT_W-1:0]      cnt_next  [NM][GROUPS];
    logic [GCNT_W-1:0]      a_cnt_reg [NM][GROUPS];
    logic                   a_valid_reg;
    logic                   a_final_reg;

    cmh_pkg::count_t        counters_reg [NM];
    cmh_pkg::count_t        sat_next     [NM];
    logic [NM-1:0]          seen_next;
    logic [NM-1:0]          seen_reg;
    logic                   emit_reg;
    cmh_pkg::mint_t         idx_reg;
    cmh_pkg::result_t       res_reg;

    logic                   a_adv;
    logic                   a_load;
    logic                   out_load;

    // stage a advances unless a run is being read out
    assign a_adv    = a_valid_reg && !emit_reg;
    assign q_ready  = !a_valid_reg || a_adv;
    assign a_load   = q_valid && q_ready;
    assign out_load = emit_reg && (!res_reg.valid || !out_stall);

    // per-group minterm tallies, eight positions a group
    always_comb
    begin
        int                pos;
        logic [GCNT_W-1:0] c;
        for (int m = 0; m < NM; m++)
        begin
            for (int g = 0; g < GROUPS; g++)
            begin
                c = '0;
                for (int j = 0; j < cmh_pkg::GROUP_BITS; j++)
                begin
                    pos = g * cmh_pkg::GROUP_BITS + j;
                    if (pos < LIVE_BITS)
                    begin
                        if (q_mints[pos] == cmh_pkg::MINT_W'(m))
                        begin
                            c = c + GCNT_W'(1);
                        end
                    end
                end
                cnt_next[m][g] = c;
            end
        end
    end

    // saturating counter update and nonzero flags
    always_comb
    begin
        logic [TOT_W-1:0] t;
        logic [SUM_W-1:0] sum;
        for (int m = 0; m < NM; m++)
        begin
            t = '0;
            for (int g = 0; g < GROUPS; g++)
            begin
                t = t + TOT_W'(a_cnt_reg[m][g]);
            end
            // positions beyond the input words always read as minterm zero
            if (m == 0)
            begin
                t = t + TOT_W'(PAD_BITS);
            end
            sum = SUM_W'(counters_reg[m]) + SUM_W'(t);
            if (sum > SUM_W'(cmh_pkg::COUNT_MAX))
            begin
                sat_next[m] = cmh_pkg::COUNT_MAX;
            end
            else
            begin
                sat_next[m] = sum[cmh_pkg::CNT_W-1:0];
            end
            seen_next[m] = (sat_next[m] != '0);
        end
    end

    // tally stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_load)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (a_adv)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_cnt_reg   <= cnt_next;
            a_final_reg <= q_final;
        end
    end

    // counters, read-out sequencing and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < NM; m++)
            begin
                counters_reg[m] <= '0;
            end
            emit_reg <= 1'b0;
            idx_reg  <= '0;
            seen_reg <= '0;
            res_reg  <= '0;
        end
        else
        begin
            if (a_adv)
            begin
                counters_reg <= sat_next;
                if (a_final_reg)
                begin
                    emit_reg <= 1'b1;
                    idx_reg  <= '0;
                    seen_reg <= seen_next;
                end
            end

            if (out_load)
            begin
                res_reg.valid       <= 1'b1;
                res_reg.minterm     <= idx_reg;
                res_reg.occurrences <= counters_reg[idx_reg];
                res_reg.seen_mask   <= seen_reg;
                res_reg.last_of_run <= (idx_reg == cmh_pkg::LAST_MINTERM);
                if (idx_reg == cmh_pkg::LAST_MINTERM)
                begin
                    emit_reg <= 1'b0;
                    for (int m = 0; m < NM; m++)
                    begin
                        counters_reg[m] <= '0;
                    end
                end
                else
                begin
                    idx_reg <= idx_reg + cmh_pkg::MINT_W'(1);
                end
            end
            else if (!out_stall)
            begin
                res_reg.valid <= 1'b0;
            end
        end
    end

    assign res = res_reg;

endmodule

/* hdl/cut_minterm_histogram_top.sv */
`timescale 1ns / 1ps

// Minterm histogram over cut-leaf simulation words. Each request carries one
// word per leaf and is taken at one request per cycle while in_stall is low;
// the front stage forms the per-position minterm codes, a two-entry queue
// decouples it from the back end, which tallies the codes in groups of eight
// positions and then adds them into sixteen saturating counters. A request
// marked final_word starts a read-out of sixteen results (minterm 0 to 15),
// one per cycle while the output is not stalled, once the final request has
// reached the counters. During the read-out the front register, the queue and
// the tally stage absorb up to four further requests before in_stall rises.
// leaf_count is written through the cfg channel, always ready; the user must
// write it only while the block is idle, which the block does not enforce.

`include "cut_minterm_histogram_top_macros.svh"

module cut_minterm_histogram_top #(
    parameter int WORD_BITS = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [cmh_pkg::IN_W-1:0]                word_leaf0,
    input  logic [cmh_pkg::IN_W-1:0]                word_leaf1,
    input  logic [cmh_pkg::IN_W-1:0]                word_leaf2,
    input  logic [cmh_pkg::IN_W-1:0]                word_leaf3,
    input  logic                                    final_word,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [cmh_pkg::MINT_W-1:0]              minterm,
    output logic [cmh_pkg::CNT_W-1:0]               occurrences,
    output logic [cmh_pkg::NUM_MINTERMS-1:0]        seen_mask,
    output logic                                    last_of_run,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [cmh_pkg::LEAF_W-1:0]              leaf_count
);

    localparam int LIVE_BITS = (WORD_BITS < cmh_pkg::IN_W) ? WORD_BITS : cmh_pkg::IN_W;
    localparam int Q_W       = LIVE_BITS * cmh_pkg::MINT_W + 1;

    logic [cmh_pkg::LEAF_W-1:0]         leaf_count_reg;
    logic                               f_valid;
    logic                               f_ready;
    cmh_pkg::mint_t [LIVE_BITS-1:0]     f_mints;
    logic                               f_final;
    logic                               b_valid;
    logic                               b_ready;
    logic [Q_W-1:0]                     b_data;
    cmh_pkg::mint_t [LIVE_BITS-1:0]     b_mints;
    logic                               b_final;
    cmh_pkg::result_t                   res;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leaf_count_reg <= cmh_pkg::LEAF_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            leaf_count_reg <= leaf_count;
        end
    end

    // classify
    cmh_front #(
        .LIVE_BITS (LIVE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .word_leaf0 (word_leaf0),
        .word_leaf1 (word_leaf1),
        .word_leaf2 (word_leaf2),
        .word_leaf3 (word_leaf3),
        .final_word (final_word),
        .leaf_count (leaf_count_reg),
        .q_valid    (f_valid),
        .q_ready    (f_ready),
        .q_mints    (f_mints),
        .q_final    (f_final)
    );

    // decoupling queue
    cmh_fifo #(
        .WIDTH (Q_W)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  ({f_final, f_mints}),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_data)
    );

    assign b_final = b_data[Q_W-1];
    assign b_mints = b_data[Q_W-2:0];

    // count and read out
    cmh_back #(
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (b_valid),
        .q_ready   (b_ready),
        .q_mints   (b_mints),
        .q_final   (b_final),
        .out_stall (out_stall),
        .res       (res)
    );

    assign out_valid   = res.valid;
    assign minterm     = res.minterm;
    assign occurrences = res.occurrences;
    assign seen_mask   = res.seen_mask;
    assign last_of_run = res.last_of_run;

    // checks
    `CMH_ASSERT_NOW(a_last_is_top, out_valid && last_of_run, minterm == cmh_pkg::LAST_MINTERM)
    `CMH_ASSERT_NEXT(a_readout_steps, out_valid && !out_stall && !last_of_run, out_valid && minterm == $past(minterm) + cmh_pkg::MINT_W'(1))
    `CMH_ASSERT_NEXT(a_mask_steady, out_valid && !out_stall && !last_of_run, seen_mask == $past(seen_mask))
    `CMH_ASSERT_NOW(a_mask_matches, out_valid, (occurrences != '0) == seen_mask[minterm])

endmodule
